// File: sv/srth_pkg.sv
`default_nettype none

package srth_pkg;

   // Default configuration of the block.
   localparam int BUCKETS_DEF     = 1024;
   localparam int WAYS_DEF        = 4;
   localparam int HIST_BINS_DEF   = 8192;
   localparam int SAMPLE_STEP_DEF = 10000;
   localparam int BIN_GROUP_DEF   = 256;

   // Feedback taps of the Galois LFSR that spaces the samples.
   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

   // Saturation value of the outstanding-sample counters.
   localparam logic [12:0] CNT_MAX = 13'd8191;

   // Request word.
   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [12:0] bin_select;
   } req_type;

   // Response word.
   typedef struct packed {
      logic        result_kind;
      logic        reuse_found;
      logic [31:0] reuse_time;
      logic [12:0] bin_index;
      logic [31:0] bin_count;
      logic        sample_dropped;
      logic [31:0] total_reuses;
      logic [12:0] peak_samples;
   } rsp_type;

   // Request kinds.
   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // One shift of the LFSR.
   function automatic logic [31:0] lfsr_next(input logic [31:0] x);
      logic [31:0] y;
      y = {1'b0, x[31:1]};
      if (x[0]) begin
         y = y ^ LFSR_TAPS;
      end
      return y;
   endfunction

endpackage

`default_nettype wire

// File: sv/srth_ram.sv
`default_nettype none

module srth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Single port: registered read + optional write per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

`default_nettype wire

// File: sv/srth_mod_unit.sv
`default_nettype none

module srth_mod_unit #(
   parameter int DIVISOR = 1024
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       start,
   input  wire logic [31:0]                                operand,
   output logic                                            done,
   output logic [(DIVISOR > 1 ? $clog2(DIVISOR) : 1)-1:0]  remainder
);

   localparam int RW = DIVISOR > 1 ? $clog2(DIVISOR) : 1;
   // Reciprocal scaled by 2^32; the quotient estimate is low by at most one.
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(DIVISOR));
   localparam logic [31:0] DIV32 = 32'(DIVISOR);

   logic [2:0]    stage_ff, stage_in;
   logic          done_ff, done_in;
   logic [31:0]   x1_ff, x1_in;
   logic [31:0]   x2_ff, x2_in;
   logic [31:0]   q_ff, q_in;
   logic [31:0]   r_ff, r_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [31:0]   fix;

   // Remainder by a constant in three steps: reciprocal multiply, multiply and
   // subtract, then one corrective subtraction.
   always_comb begin
      stage_in = {stage_ff[1:0], start};
      done_in  = stage_ff[2];
      x1_in    = operand;
      q_in     = 32'((64'(x1_ff) * 64'(RECIP)) >> 32);
      x2_in    = x1_ff;
      r_in     = x2_ff - q_ff * DIV32;
      fix      = (r_ff >= DIV32) ? r_ff - DIV32 : r_ff;
      rem_in   = fix[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      x1_ff  <= x1_in;
      x2_ff  <= x2_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: sv/srth_bin_unit.sv
`default_nettype none

module srth_bin_unit #(
   parameter int HIST_BINS = 8192,
   parameter int BIN_GROUP = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [31:0]                  time_value,
   output logic                              done,
   output logic [$clog2(HIST_BINS)-1:0]      bin
);

   localparam int IW = $clog2(HIST_BINS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [31:0]   val_ff, val_in;
   logic [33:0]   pos_ff, pos_in;
   logic [33:0]   span_ff, span_in;
   logic [5:0]    sh_ff, sh_in;
   logic [31:0]   idx_ff, idx_in;
   logic [IW-1:0] bin_ff, bin_in;
   logic [33:0]   val_ext;
   logic [33:0]   diff;
   logic [33:0]   quot;
   logic [31:0]   fin;

   // One octave per cycle: each octave spans BIN_GROUP bins of width step.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      pos_in  = pos_ff;
      span_in = span_ff;
      sh_in   = sh_ff;
      idx_in  = idx_ff;
      bin_in  = bin_ff;
      val_ext = {2'b00, val_ff};
      diff    = val_ext - pos_ff;
      quot    = (diff + ((34'd1 << sh_ff) - 34'd1)) >> sh_ff;
      fin     = idx_ff;
      if (start) begin
         busy_in = 1'b1;
         val_in  = time_value;
         pos_in  = '0;
         span_in = 34'(BIN_GROUP);
         sh_in   = '0;
         idx_in  = '0;
      end else if (busy_ff) begin
         if (pos_ff + span_ff < val_ext) begin
            pos_in  = pos_ff + span_ff;
            span_in = {span_ff[32:0], 1'b0};
            sh_in   = sh_ff + 6'd1;
            idx_in  = idx_ff + 32'(BIN_GROUP);
         end else begin
            // Round the offset inside the octave up to whole bins.
            if (pos_ff < val_ext) begin
               fin = idx_ff + quot[31:0];
            end
            if (fin > 32'(HIST_BINS - 1)) begin
               fin = 32'(HIST_BINS - 1);
            end
            bin_in  = fin[IW-1:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      pos_ff  <= pos_in;
      span_ff <= span_in;
      sh_ff   <= sh_in;
      idx_ff  <= idx_in;
      bin_ff  <= bin_in;
   end

   assign done = done_ff;
   assign bin  = bin_ff;

endmodule

`default_nettype wire

// File: sv/sampled_reuse_time_histogram_unit.sv
`default_nettype none

// Sampled reuse-time histogram. Each access word bumps the access count, looks its
// address up in a set-associative sample table (BUCKETS rows of WAYS entries held in
// one RAM row each) and, on a match, frees the entry and counts the reuse time in a
// log-linear histogram RAM. Accesses at LFSR-spaced positions are stored as samples
// in a free way, or dropped if none is free. Words are handled one at a time.
// An access without a reuse passes acceptance, the bucket remainder (reciprocal
// multiply, multiply and subtract, correction), the table read-modify-write and the
// response stage. A reuse adds the bin search, one step per octave of the reuse time,
// and the histogram update; a due sample adds the next gap remainder. A bin read goes
// through a histogram RAM read to the response stage. After reset a clearing pass
// over max(BUCKETS, HIST_BINS) addresses and the first gap computation run before the
// first word is taken; a seed write computes a new first gap. A finished response
// waits in an output register.
module sampled_reuse_time_histogram_unit
   import srth_pkg::*;
#(
   parameter int BUCKETS     = BUCKETS_DEF,
   parameter int WAYS        = WAYS_DEF,
   parameter int HIST_BINS   = HIST_BINS_DEF,
   parameter int SAMPLE_STEP = SAMPLE_STEP_DEF,
   parameter int BIN_GROUP   = BIN_GROUP_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);

   localparam int GAP_MOD = 2 * SAMPLE_STEP - 1;
   localparam int EW      = 65;
   localparam int ROWW    = WAYS * EW;
   localparam int BKW     = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
   localparam int GW      = GAP_MOD > 1 ? $clog2(GAP_MOD) : 1;
   localparam int HBW     = $clog2(HIST_BINS);
   localparam int CLR_N   = BUCKETS > HIST_BINS ? BUCKETS : HIST_BINS;
   localparam int CW      = $clog2(CLR_N);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b00_0000_0001,
      S_IDLE  = 10'b00_0000_0010,
      S_SEED  = 10'b00_0000_0100,
      S_BKT   = 10'b00_0000_1000,
      S_LOOK  = 10'b00_0001_0000,
      S_BIN   = 10'b00_0010_0000,
      S_HUPD  = 10'b00_0100_0000,
      S_GAP   = 10'b00_1000_0000,
      S_RDH   = 10'b01_0000_0000,
      S_OUT   = 10'b10_0000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic          pend_ff, pend_in;
   logic [31:0]   lfsr_ff, lfsr_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   next_ff, next_in;
   logic [31:0]   base_ff, base_in;
   logic [12:0]   outs_ff, outs_in;
   logic [12:0]   peak_ff, peak_in;
   logic [31:0]   total_ff, total_in;
   req_type       item_ff, item_in;
   logic [BKW-1:0] bucket_ff, bucket_in;
   logic          found_ff, found_in;
   logic [31:0]   rtime_ff, rtime_in;
   logic          due_ff, due_in;
   logic          drop_ff, drop_in;
   logic          selok_ff, selok_in;
   logic [12:0]   bidx_ff, bidx_in;
   logic [HBW-1:0] hidx_ff, hidx_in;
   logic [31:0]   bcount_ff, bcount_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // Memory ports.
   logic           t_we;
   logic [BKW-1:0] t_addr;
   logic [ROWW-1:0] t_wdata, t_rdata;
   logic           h_we;
   logic [HBW-1:0] h_addr;
   logic [31:0]    h_wdata, h_rdata;

   // Remainder units and bin search.
   logic           bkt_start, bkt_done;
   logic [BKW-1:0] bkt_rem;
   logic           gap_start, gap_done;
   logic [31:0]    gap_operand;
   logic [GW-1:0]  gap_rem;
   logic           b_start, b_done;
   logic [HBW-1:0] b_bin;

   // Lookup and insertion scratch.
   logic [ROWW-1:0] row;
   logic          hit, placed, due;
   logic [31:0]   stamp;
   logic [12:0]   o1, o2;
   logic [31:0]   sel_ext, gap, bin_ext;
   logic          accept;

   srth_ram #(.WIDTH(ROWW), .DEPTH(BUCKETS)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .addr    (t_addr),
      .wr_data (t_wdata),
      .rd_data (t_rdata)
   );

   srth_ram #(.WIDTH(32), .DEPTH(HIST_BINS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .addr    (h_addr),
      .wr_data (h_wdata),
      .rd_data (h_rdata)
   );

   srth_mod_unit #(.DIVISOR(BUCKETS)) u_bkt_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (bkt_start),
      .operand   (req_data.address),
      .done      (bkt_done),
      .remainder (bkt_rem)
   );

   srth_mod_unit #(.DIVISOR(GAP_MOD)) u_gap_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (gap_start),
      .operand   (gap_operand),
      .done      (gap_done),
      .remainder (gap_rem)
   );

   srth_bin_unit #(.HIST_BINS(HIST_BINS), .BIN_GROUP(BIN_GROUP)) u_bin (
      .clock      (clock),
      .reset      (reset),
      .start      (b_start),
      .time_value (rtime_in),
      .done       (b_done),
      .bin        (b_bin)
   );

   assign req_ready = (state_ff == S_IDLE) && !pend_ff && !csr_we;
   assign accept    = req_valid && req_ready;
   assign sel_ext   = 32'(req_data.bin_select);
   assign gap       = 32'(gap_rem) + 32'd1;
   assign bin_ext   = 32'(b_bin);

   // Sequencer with the table and histogram read-modify-write.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      lfsr_in      = lfsr_ff;
      acc_in       = acc_ff;
      next_in      = next_ff;
      base_in      = base_ff;
      outs_in      = outs_ff;
      peak_in      = peak_ff;
      total_in     = total_ff;
      item_in      = item_ff;
      bucket_in    = bucket_ff;
      found_in     = found_ff;
      rtime_in     = rtime_ff;
      due_in       = due_ff;
      drop_in      = drop_ff;
      selok_in     = selok_ff;
      bidx_in      = bidx_ff;
      hidx_in      = hidx_ff;
      bcount_in    = bcount_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      t_we         = 1'b0;
      t_addr       = bucket_ff;
      t_wdata      = '0;
      h_we         = 1'b0;
      h_addr       = hidx_ff;
      h_wdata      = '0;
      bkt_start    = 1'b0;
      gap_start    = 1'b0;
      gap_operand  = lfsr_ff;
      b_start      = 1'b0;
      row          = t_rdata;
      hit          = 1'b0;
      placed       = 1'b0;
      stamp        = '0;
      due          = (acc_ff == next_ff);
      o1           = outs_ff;
      o2           = outs_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            t_we    = (32'(clr_ff) < 32'(BUCKETS));
            t_addr  = clr_ff[BKW-1:0];
            h_we    = (32'(clr_ff) < 32'(HIST_BINS));
            h_addr  = clr_ff[HBW-1:0];
            clr_in  = clr_ff + CW'(1);
            if (32'(clr_ff) == 32'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (pend_ff && !csr_we) begin
               // First gap after a reseed counts from the current access.
               gap_start = 1'b1;
               base_in   = acc_ff;
               pend_in   = 1'b0;
               state_in  = S_SEED;
            end else if (accept) begin
               item_in   = req_data;
               found_in  = 1'b0;
               rtime_in  = '0;
               due_in    = 1'b0;
               drop_in   = 1'b0;
               bidx_in   = '0;
               bcount_in = '0;
               if (req_data.kind == KIND_ACCESS) begin
                  acc_in    = acc_ff + 32'd1;
                  bkt_start = 1'b1;
                  state_in  = S_BKT;
               end else begin
                  bidx_in  = req_data.bin_select;
                  selok_in = (sel_ext < 32'(HIST_BINS));
                  h_addr   = sel_ext[HBW-1:0];
                  state_in = S_RDH;
               end
            end
         end
         S_SEED: begin
            if (gap_done) begin
               next_in  = base_ff + gap;
               state_in = S_IDLE;
            end
         end
         S_BKT: begin
            if (bkt_done) begin
               bucket_in = bkt_rem;
               t_addr    = bkt_rem;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            // Lowest valid way with a matching address is freed.
            for (int w = 0; w < WAYS; w++) begin
               if (!hit && row[w*EW+64] && row[w*EW+32 +: 32] == item_ff.address) begin
                  hit          = 1'b1;
                  stamp        = row[w*EW +: 32];
                  row[w*EW+64] = 1'b0;
               end
            end
            // A due sample takes the lowest free way.
            if (due) begin
               for (int w = 0; w < WAYS; w++) begin
                  if (!placed && !row[w*EW+64]) begin
                     placed         = 1'b1;
                     row[w*EW +: EW] = {1'b1, item_ff.address, acc_ff};
                  end
               end
               lfsr_in = lfsr_next(lfsr_ff);
            end
            t_we    = 1'b1;
            t_wdata = row;
            if (hit && outs_ff != 13'd0) begin
               o1 = outs_ff - 13'd1;
            end
            o2 = o1;
            if (placed && o1 < CNT_MAX) begin
               o2 = o1 + 13'd1;
            end
            outs_in  = o2;
            if (o2 > peak_ff) begin
               peak_in = o2;
            end
            found_in = hit;
            due_in   = due;
            drop_in  = due && !placed;
            if (hit) begin
               rtime_in = acc_ff - stamp;
               b_start  = 1'b1;
               state_in = S_BIN;
            end else if (due) begin
               gap_start   = 1'b1;
               gap_operand = lfsr_next(lfsr_ff);
               base_in     = next_ff;
               state_in    = S_GAP;
            end else begin
               state_in = S_OUT;
            end
         end
         S_BIN: begin
            if (b_done) begin
               hidx_in  = b_bin;
               bidx_in  = bin_ext[12:0];
               h_addr   = b_bin;
               state_in = S_HUPD;
            end
         end
         S_HUPD: begin
            // Saturating bin and total counts.
            h_we    = 1'b1;
            h_addr  = hidx_ff;
            h_wdata = (h_rdata == 32'hFFFF_FFFF) ? h_rdata : h_rdata + 32'd1;
            if (total_ff != 32'hFFFF_FFFF) begin
               total_in = total_ff + 32'd1;
            end
            if (due_ff) begin
               gap_start = 1'b1;
               base_in   = next_ff;
               state_in  = S_GAP;
            end else begin
               state_in = S_OUT;
            end
         end
         S_GAP: begin
            if (gap_done) begin
               next_in  = base_ff + gap;
               state_in = S_OUT;
            end
         end
         S_RDH: begin
            bcount_in = selok_ff ? h_rdata : 32'd0;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.result_kind    = item_ff.kind;
               rsp_in.reuse_found    = found_ff;
               rsp_in.reuse_time     = rtime_ff;
               rsp_in.bin_index      = bidx_ff;
               rsp_in.bin_count      = bcount_ff;
               rsp_in.sample_dropped = drop_ff;
               rsp_in.total_reuses   = total_ff;
               rsp_in.peak_samples   = peak_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A seed write restarts the LFSR; a zero seed counts as one.
      if (csr_we) begin
         lfsr_in = (csr_wdata == 32'd0) ? 32'd1 : csr_wdata;
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b1;
         lfsr_ff      <= 32'd1;
         acc_ff       <= '0;
         next_ff      <= '0;
         outs_ff      <= '0;
         peak_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         lfsr_ff      <= lfsr_in;
         acc_ff       <= acc_in;
         next_ff      <= next_in;
         outs_ff      <= outs_in;
         peak_ff      <= peak_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff   <= base_in;
      item_ff   <= item_in;
      bucket_ff <= bucket_in;
      found_ff  <= found_in;
      rtime_ff  <= rtime_in;
      due_ff    <= due_in;
      drop_ff   <= drop_in;
      selok_ff  <= selok_in;
      bidx_ff   <= bidx_in;
      hidx_ff   <= hidx_in;
      bcount_ff <= bcount_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: tb/sampled_reuse_time_histogram_unit_test.sv
`default_nettype none

module sampled_reuse_time_histogram_unit_test;
   import srth_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ROWS = BUCKETS_DEF;
   localparam int TABLE_WAYS = WAYS_DEF;
   localparam int BIN_TOTAL  = HIST_BINS_DEF;
   localparam int BIN_WIDTH  = BIN_GROUP_DEF;
   localparam logic [31:0] GAP_SPAN = 2 * SAMPLE_STEP_DEF - 1;
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
   localparam int SETTLE_CYCLES = 120;
   localparam int LONG_HOLD = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   sampled_reuse_time_histogram_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the block's state.
   logic [31:0] shadow_count;
   logic [31:0] shadow_next;
   logic [31:0] shadow_lfsr;
   bit          sample_live [TABLE_ROWS*TABLE_WAYS];
   logic [31:0] sample_addr [TABLE_ROWS*TABLE_WAYS];
   logic [31:0] sample_stamp [TABLE_ROWS*TABLE_WAYS];
   logic [31:0] bin_tally [BIN_TOTAL];
   logic [31:0] reuse_tally;
   logic [12:0] live_samples;
   logic [12:0] live_peak;

   rsp_type expected_words [$];
   int mismatches = 0;
   int seen_accesses = 0, seen_reads = 0, seen_reuses = 0, seen_drops = 0;
   int send_idle = 0, recv_idle = 0;
   int hold_requests = 0;

   function automatic logic [12:0] reuse_bin(logic [31:0] span);
      longint unsigned pos = 0, step = 1, idx = 0;
      longint unsigned v;
      v = span;
      while (pos + step * BIN_WIDTH < v) begin
         pos += step * BIN_WIDTH;
         step = step << 1;
         idx += BIN_WIDTH;
      end
      if (pos < v) idx += (v - pos + step - 1) / step;
      if (idx > BIN_TOTAL - 1) idx = BIN_TOTAL - 1;
      return idx[12:0];
   endfunction

   function automatic logic [31:0] gap_from(logic [31:0] x);
      return x % GAP_SPAN + 32'd1;
   endfunction

   function automatic logic [31:0] lfsr_shift(logic [31:0] x);
      logic [31:0] y;
      y = x >> 1;
      if (x[0]) y = y ^ 32'h8020_0003;
      return y;
   endfunction

   // A new seed restarts the sample spacing from the current access count.
   task automatic reseed_shadow(logic [31:0] seed);
      if (seed == 32'd0) seed = 32'd1;
      shadow_lfsr = seed;
      shadow_next = shadow_count + gap_from(seed);
   endtask

   // Works out the response to one request word and updates the shadow state.
   function automatic rsp_type histogram_response(req_type w);
      rsp_type r;
      int base, e;
      bit placed;
      r = '0;
      r.result_kind = w.kind;
      if (w.kind == KIND_READ) begin
         r.bin_index = w.bin_select;
         r.bin_count = bin_tally[w.bin_select];
         seen_reads++;
      end else begin
         seen_accesses++;
         base = (w.address % TABLE_ROWS) * TABLE_WAYS;
         shadow_count = shadow_count + 32'd1;
         for (int k = 0; k < TABLE_WAYS; k++) begin
            e = base + k;
            if (!r.reuse_found && sample_live[e] && sample_addr[e] == w.address) begin
               r.reuse_found = 1'b1;
               r.reuse_time = shadow_count - sample_stamp[e];
               sample_live[e] = 1'b0;
               if (live_samples > 0) live_samples--;
            end
         end
         if (r.reuse_found) begin
            seen_reuses++;
            r.bin_index = reuse_bin(r.reuse_time);
            if (bin_tally[r.bin_index] != SAT32) bin_tally[r.bin_index]++;
            if (reuse_tally != SAT32) reuse_tally++;
         end
         if (shadow_count == shadow_next) begin
            placed = 1'b0;
            for (int k = 0; k < TABLE_WAYS; k++) begin
               e = base + k;
               if (!placed && !sample_live[e]) begin
                  sample_live[e] = 1'b1;
                  sample_addr[e] = w.address;
                  sample_stamp[e] = shadow_count;
                  placed = 1'b1;
               end
            end
            if (placed) begin
               if (live_samples < CNT_MAX) live_samples++;
            end else begin
               r.sample_dropped = 1'b1;
               seen_drops++;
            end
            shadow_lfsr = lfsr_shift(shadow_lfsr);
            shadow_next = shadow_next + gap_from(shadow_lfsr);
         end
         if (live_samples > live_peak) live_peak = live_samples;
      end
      r.total_reuses = reuse_tally;
      r.peak_samples = live_peak;
      return r;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   // Receiver: random stalls, plus a long hold-off when one is asked for.
   int hold_left = 0;
   int holds_taken = 0;
   always @(posedge clock) begin
      if (hold_requests != holds_taken) begin
         holds_taken = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom % 100) >= recv_idle;
      end
   end

   // Each response word is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("unexpected response word at %0t", $realtime);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.result_kind !== want.result_kind)
               report("result_kind", 32'(rsp_data.result_kind), 32'(want.result_kind));
            if (rsp_data.reuse_found !== want.reuse_found)
               report("reuse_found", 32'(rsp_data.reuse_found), 32'(want.reuse_found));
            if (rsp_data.reuse_time !== want.reuse_time)
               report("reuse_time", rsp_data.reuse_time, want.reuse_time);
            if (rsp_data.bin_index !== want.bin_index)
               report("bin_index", 32'(rsp_data.bin_index), 32'(want.bin_index));
            if (rsp_data.bin_count !== want.bin_count)
               report("bin_count", rsp_data.bin_count, want.bin_count);
            if (rsp_data.sample_dropped !== want.sample_dropped)
               report("sample_dropped", 32'(rsp_data.sample_dropped),
                      32'(want.sample_dropped));
            if (rsp_data.total_reuses !== want.total_reuses)
               report("total_reuses", rsp_data.total_reuses, want.total_reuses);
            if (rsp_data.peak_samples !== want.peak_samples)
               report("peak_samples", 32'(rsp_data.peak_samples), 32'(want.peak_samples));
         end
      end
   end

   // Offers one request word and waits for it to be taken.
   task automatic send_word(req_type w);
      while (($urandom % 100) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(histogram_response(w));
   endtask

   task automatic send_access(logic [31:0] a);
      req_type w;
      w = '0;
      w.kind = KIND_ACCESS;
      w.address = a;
      w.bin_select = 13'($urandom);
      send_word(w);
   endtask

   task automatic send_read(logic [12:0] b);
      req_type w;
      w = '0;
      w.kind = KIND_READ;
      w.address = $urandom;
      w.bin_select = b;
      send_word(w);
   endtask

   // Drains the block, then writes the seed register.
   task automatic write_seed(logic [31:0] seed);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= seed;
      @(posedge clock);
      csr_we <= 1'b0;
      reseed_shadow(seed);
   endtask

   // Freshly cleared histogram reads back as zero at both ends and at two bins in between.
   task automatic test_cleared_bins();
      send_read(13'd0);
      send_read(13'h1FFF);
      send_read(13'h0AAA);
      send_read(13'h1555);
   endtask

   // A zero seed gives a gap of two accesses; five samples in one bucket overflow it.
   task automatic test_full_bucket();
      for (int i = 0; i < TABLE_WAYS + 1; i++) begin
         write_seed(32'd0);
         send_access(32'd7 + 32'd1024 * i + 32'd1);
         send_access(32'd7 + 32'd1024 * i);
      end
      send_access(32'd7);
      send_access(32'd7 + 32'd1024 * 2);
      send_read(13'd0);
      send_read(reuse_bin(32'd20));
   endtask

   // The largest seed, with the extreme addresses.
   task automatic test_extreme_seed();
      write_seed(SAT32);
      send_access(32'd0);
      send_access(SAT32);
      send_access(32'd0);
      send_access(SAT32);
   endtask

   // Phases of accesses and bin reads over a small address pool, so that samples come back.
   task automatic test_random_phases(int phases, int words);
      logic [31:0] pool [12];
      logic [9:0] shared;
      for (int p = 0; p < phases; p++) begin
         write_seed(($urandom % 4 == 0) ? $urandom : $urandom_range(0, 60));
         shared = 10'($urandom);
         foreach (pool[i]) begin
            pool[i] = $urandom;
            if (i % 2 == 0) pool[i][9:0] = shared;
         end
         for (int n = 0; n < words; n++) begin
            if ($urandom % 100 < 85) send_access(pool[$urandom % 12]);
            else if ($urandom % 3 == 0) send_read(13'($urandom));
            else send_read(13'($urandom_range(0, 80)));
         end
      end
   endtask

   // Receiver holds off for a long stretch while words keep coming.
   task automatic test_backpressure();
      hold_requests++;
      for (int n = 0; n < 20; n++) send_access($urandom_range(0, 7));
   endtask

   initial begin
      foreach (sample_live[i]) begin
         sample_live[i] = 1'b0;
         sample_addr[i] = '0;
         sample_stamp[i] = '0;
      end
      foreach (bin_tally[i]) bin_tally[i] = '0;
      shadow_count = '0;
      reuse_tally = '0;
      live_samples = '0;
      live_peak = '0;
      reseed_shadow(32'd1);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle = 18;
      recv_idle = 63;
      test_cleared_bins();
      test_full_bucket();
      test_extreme_seed();
      test_random_phases(7, 90);
      send_idle = 63;
      recv_idle = 18;
      test_random_phases(7, 90);
      test_backpressure();
      send_idle = 0;
      recv_idle = 0;
      test_random_phases(7, 90);

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d accesses and %0d bin reads, with %0d reuses and %0d dropped samples.",
               seen_accesses, seen_reads, seen_reuses, seen_drops);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hung block.
   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
